>>> hw/rtl/mpa_sync_pkg.sv
// ----------------------------------------------------------------------------
// mpa_sync_pkg
// Shared types, codes and lookup tables for the MPEG audio frame sync search.
// ----------------------------------------------------------------------------
package mpa_sync_pkg;

    // Input opcodes
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_FOUND = 2'd0;
    localparam logic [1:0] STATUS_LIMIT = 2'd1;
    localparam logic [1:0] STATUS_END   = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEARCH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_HEADER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_L1   = 2'd2;

    // Reset values of the configuration registers
    localparam logic [23:0] MAX_SEARCH_RST = 24'd131072;
    localparam logic [31:0] REF_HEADER_RST = 32'd0;
    localparam logic        ALLOW_L1_RST   = 1'b1;

    // Header masks: sync bits, and sync/version/layer/rate bits
    localparam logic [31:0] HDR_SYNC_PAT = 32'hFFE0_0000;
    localparam logic [31:0] TYPE_MASK    = 32'hFFFE_0C00;

    // Divider geometry: dividend up to 125 * 1152 * 448 fits in 26 bits
    localparam int DVD_W = 26;
    localparam int REM_W = 16;
    localparam int CNT_W = $clog2(DVD_W);
    localparam int PROD_W = 27;
    localparam int COEF_W = 18;

    // Bytes-per-frame numerator coefficients (times bitrate in kbit/s)
    localparam logic [COEF_W-1:0] COEF_L1   = COEF_W'(12000);
    localparam logic [COEF_W-1:0] COEF_576  = COEF_W'(125 * 576);
    localparam logic [COEF_W-1:0] COEF_1152 = COEF_W'(125 * 1152);

    // Frame-time numerators: 1000 * den * samples
    localparam logic [DVD_W-1:0] TNUM_L1_D1     = DVD_W'(1000 * 384);
    localparam logic [DVD_W-1:0] TNUM_L1_D147   = DVD_W'(1000 * 147 * 384);
    localparam logic [DVD_W-1:0] TNUM_576_D1    = DVD_W'(1000 * 576);
    localparam logic [DVD_W-1:0] TNUM_576_D49   = DVD_W'(1000 * 49 * 576);
    localparam logic [DVD_W-1:0] TNUM_1152_D1   = DVD_W'(1000 * 1152);
    localparam logic [DVD_W-1:0] TNUM_1152_D49  = DVD_W'(1000 * 49 * 1152);

    localparam logic [10:0] SAMPLES_L1   = 11'd384;
    localparam logic [10:0] SAMPLES_HALF = 11'd576;
    localparam logic [10:0] SAMPLES_FULL = 11'd1152;

    localparam logic [7:0] DEN_ONE = 8'd1;
    localparam logic [7:0] DEN_L1  = 8'd147;
    localparam logic [7:0] DEN_L23 = 8'd49;

    // One result beat
    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] skipped_bytes;
        logic [1:0]  version_code;
        logic [1:0]  layer_code;
        logic [8:0]  bitrate_kbps;
        logic [15:0] sample_rate_hz;
        logic        padding_bit;
        logic [1:0]  chan_mode;
        logic [11:0] frame_bytes;
        logic [10:0] frame_nsamp;
        logic [12:0] frame_time_num;
        logic [7:0]  frame_time_den;
    } t_result;

    // Bitrate table, rows: MPEG1 L1, L2, L3, MPEG2/2.5 L1, MPEG2/2.5 L2/L3
    function automatic logic [8:0] f_bitrate(input logic [2:0] row, input logic [3:0] idx);
        logic [8:0] br;
        br = 9'd0;
        case (row)
            3'd0: begin
                case (idx)
                    4'd1: br = 9'd32;   4'd2: br = 9'd64;   4'd3: br = 9'd96;
                    4'd4: br = 9'd128;  4'd5: br = 9'd160;  4'd6: br = 9'd192;
                    4'd7: br = 9'd224;  4'd8: br = 9'd256;  4'd9: br = 9'd288;
                    4'd10: br = 9'd320; 4'd11: br = 9'd352; 4'd12: br = 9'd384;
                    4'd13: br = 9'd416; 4'd14: br = 9'd448;
                    default: br = 9'd0;
                endcase
            end
            3'd1: begin
                case (idx)
                    4'd1: br = 9'd32;   4'd2: br = 9'd48;   4'd3: br = 9'd56;
                    4'd4: br = 9'd64;   4'd5: br = 9'd80;   4'd6: br = 9'd96;
                    4'd7: br = 9'd112;  4'd8: br = 9'd128;  4'd9: br = 9'd160;
                    4'd10: br = 9'd192; 4'd11: br = 9'd224; 4'd12: br = 9'd256;
                    4'd13: br = 9'd320; 4'd14: br = 9'd384;
                    default: br = 9'd0;
                endcase
            end
            3'd2: begin
                case (idx)
                    4'd1: br = 9'd32;   4'd2: br = 9'd40;   4'd3: br = 9'd48;
                    4'd4: br = 9'd56;   4'd5: br = 9'd64;   4'd6: br = 9'd80;
                    4'd7: br = 9'd96;   4'd8: br = 9'd112;  4'd9: br = 9'd128;
                    4'd10: br = 9'd160; 4'd11: br = 9'd192; 4'd12: br = 9'd224;
                    4'd13: br = 9'd256; 4'd14: br = 9'd320;
                    default: br = 9'd0;
                endcase
            end
            3'd3: begin
                case (idx)
                    4'd1: br = 9'd32;   4'd2: br = 9'd48;   4'd3: br = 9'd56;
                    4'd4: br = 9'd64;   4'd5: br = 9'd80;   4'd6: br = 9'd96;
                    4'd7: br = 9'd112;  4'd8: br = 9'd128;  4'd9: br = 9'd144;
                    4'd10: br = 9'd160; 4'd11: br = 9'd176; 4'd12: br = 9'd192;
                    4'd13: br = 9'd224; 4'd14: br = 9'd256;
                    default: br = 9'd0;
                endcase
            end
            3'd4: begin
                case (idx)
                    4'd1: br = 9'd8;    4'd2: br = 9'd16;   4'd3: br = 9'd24;
                    4'd4: br = 9'd32;   4'd5: br = 9'd40;   4'd6: br = 9'd48;
                    4'd7: br = 9'd56;   4'd8: br = 9'd64;   4'd9: br = 9'd80;
                    4'd10: br = 9'd96;  4'd11: br = 9'd112; 4'd12: br = 9'd128;
                    4'd13: br = 9'd144; 4'd14: br = 9'd160;
                    default: br = 9'd0;
                endcase
            end
            default: br = 9'd0;
        endcase
        return br;
    endfunction

    // Sample rate by version code and rate index
    function automatic logic [15:0] f_sample_rate(input logic [1:0] ver, input logic [1:0] fri);
        logic [15:0] fs;
        fs = 16'd0;
        case ({ver, fri})
            4'b00_00: fs = 16'd44100;
            4'b00_01: fs = 16'd48000;
            4'b00_10: fs = 16'd32000;
            4'b01_00: fs = 16'd22050;
            4'b01_01: fs = 16'd24000;
            4'b01_10: fs = 16'd16000;
            4'b10_00: fs = 16'd11025;
            4'b10_01: fs = 16'd12000;
            4'b10_10: fs = 16'd8000;
            default:  fs = 16'd0;
        endcase
        return fs;
    endfunction

    // Frame-length numerator coefficient
    function automatic logic [COEF_W-1:0] f_size_coef(input logic layer_one, input logic half);
        logic [COEF_W-1:0] c;
        if (layer_one) begin
            c = COEF_L1;
        end else if (half) begin
            c = COEF_576;
        end else begin
            c = COEF_1152;
        end
        return c;
    endfunction

    // Frame-time numerator
    function automatic logic [DVD_W-1:0] f_time_dividend(input logic layer_one,
                                                         input logic half,
                                                         input logic den_one);
        logic [DVD_W-1:0] t;
        if (layer_one) begin
            t = den_one ? TNUM_L1_D1 : TNUM_L1_D147;
        end else if (half) begin
            t = den_one ? TNUM_576_D1 : TNUM_576_D49;
        end else begin
            t = den_one ? TNUM_1152_D1 : TNUM_1152_D49;
        end
        return t;
    endfunction

endpackage

>>> hw/rtl/mpeg_audio_frame_sync_search_top.sv
// ----------------------------------------------------------------------------
// mpeg_audio_frame_sync_search_top
// Byte-wise search for an MPEG audio frame header, with header decode and a
// shared restoring divider for frame length and frame duration.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Beat
//  in        input      i_in_valid / o_in_stall   i_op, i_data_byte
//  out       output     o_out_valid / i_out_stall status and decoded header
//  cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  A byte that finds no header only shifts the window; a limit or end beat
//  passes its result through the pending register before the input opens again.
//  A header hit takes these steps: accept, one multiply, two 26-step
//  divisions (one quotient bit a cycle), move to the output.
//  Reset is synchronous; the window, the position and the queues clear.
//  The input stalls while the divider works or a result is pending.
// ----------------------------------------------------------------------------
module mpeg_audio_frame_sync_search_top
    import mpa_sync_pkg::*;
#(
    parameter int POSITION_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_op,
    input  logic [7:0]           i_data_byte,
    // results
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_status,
    output logic [23:0]          o_skipped_bytes,
    output logic [1:0]           o_version_code,
    output logic [1:0]           o_layer_code,
    output logic [8:0]           o_bitrate_kbps,
    output logic [15:0]          o_sample_rate_hz,
    output logic                 o_padding_bit,
    output logic [1:0]           o_chan_mode,
    output logic [11:0]          o_frame_bytes,
    output logic [10:0]          o_frame_nsamp,
    output logic [12:0]          o_frame_time_num,
    output logic [7:0]           o_frame_time_den,
    // configuration
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int CW = (POSITION_BITS > 24) ? POSITION_BITS : 24;
    localparam int RES_W = $bits(t_result);
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [CW-1:0] SKIP_MAX = CW'(24'hFF_FFFF);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DVD_W - 1);

    // Sequencer states
    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_MUL      = 2'd1;
    localparam logic [1:0] ST_DIV_SIZE = 2'd2;
    localparam logic [1:0] ST_DIV_TIME = 2'd3;

    logic [1:0]               r_state;
    logic [CNT_W-1:0]         r_cnt;
    logic [DVD_W-1:0]         r_dvd;
    logic [REM_W-1:0]         r_rem;
    logic [31:0]              r_win;
    logic [POSITION_BITS-1:0] r_pos;
    logic [23:0]              r_max_search;
    logic [31:0]              r_ref_hdr;
    logic                     r_allow_l1;
    t_result                  r_pend;
    logic                     r_pend_valid;
    t_result                  r_out;
    logic                     r_out_valid;

    logic [31:0]              n_win;
    logic [POSITION_BITS-1:0] n_pos;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_search <= MAX_SEARCH_RST;
            r_ref_hdr    <= REF_HEADER_RST;
            r_allow_l1   <= ALLOW_L1_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MAX_SEARCH: r_max_search <= i_cfg_data[23:0];
                CFG_REF_HEADER: r_ref_hdr    <= i_cfg_data;
                CFG_ALLOW_L1:   r_allow_l1   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Window shift, position count, limit test
    // ------------------------------------------------------------------
    logic          w_in_acc;
    logic [CW-1:0] w_pos_ext;
    logic [CW-1:0] w_skip_raw;
    logic [23:0]   w_skip;
    logic          w_limit_hit;

    assign o_in_stall = (r_state != ST_IDLE) || r_pend_valid;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign n_win = {r_win[23:0], i_data_byte};
    assign n_pos = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;

    assign w_pos_ext   = CW'(n_pos);
    assign w_limit_hit = (r_max_search != 24'd0) && (w_pos_ext > CW'(r_max_search));
    assign w_skip_raw  = (w_pos_ext >= CW'(4)) ? w_pos_ext - CW'(4) : '0;
    assign w_skip      = (w_skip_raw > SKIP_MAX) ? 24'hFF_FFFF : w_skip_raw[23:0];

    // ------------------------------------------------------------------
    // Header validity and decode of the shifted window
    // ------------------------------------------------------------------
    logic        w_hdr_ok;
    logic        w_type_ok;
    logic [31:0] w_ref_type;
    logic [1:0]  w_ver;
    logic [1:0]  w_lay;
    logic [2:0]  w_row;
    logic [1:0]  w_fri;
    logic        w_half;

    assign w_hdr_ok = ((n_win & HDR_SYNC_PAT) == HDR_SYNC_PAT)
                   && (n_win[20:19] != 2'b01)
                   && (n_win[18:17] != 2'b00)
                   && !((n_win[18:17] == 2'b11) && !r_allow_l1)
                   && (n_win[15:12] != 4'd0) && (n_win[15:12] != 4'd15)
                   && (n_win[11:10] != 2'b11);

    assign w_ref_type = r_ref_hdr & TYPE_MASK;
    assign w_type_ok  = (w_ref_type == 32'd0) || (w_ref_type == (n_win & TYPE_MASK));

    assign w_ver  = (n_win[20:19] == 2'b11) ? 2'd0 : (n_win[20:19] == 2'b10) ? 2'd1 : 2'd2;
    assign w_lay  = 2'd3 - n_win[18:17];
    assign w_fri  = n_win[11:10];
    assign w_row  = (w_ver == 2'd0) ? {1'b0, w_lay} : (w_lay == 2'd0) ? 3'd3 : 3'd4;
    assign w_half = (w_ver != 2'd0) && (w_lay == 2'd2);

    // ------------------------------------------------------------------
    // Shared divider step: one quotient bit a cycle, quotient shifts into
    // the dividend register
    // ------------------------------------------------------------------
    logic [REM_W:0]    w_rem_sh;
    logic              w_qbit;
    logic [REM_W-1:0]  w_rem_nx;
    logic [DVD_W-1:0]  w_dvd_nx;
    logic [PROD_W-1:0] w_prod;
    logic [11:0]       w_size_sum;
    logic              w_layer_one;

    assign w_rem_sh = {r_rem, r_dvd[DVD_W-1]};
    assign w_qbit   = (w_rem_sh >= {1'b0, r_pend.sample_rate_hz});
    assign w_rem_nx = w_qbit ? REM_W'(w_rem_sh - {1'b0, r_pend.sample_rate_hz})
                             : w_rem_sh[REM_W-1:0];
    assign w_dvd_nx = {r_dvd[DVD_W-2:0], w_qbit};

    assign w_layer_one = (r_pend.layer_code == 2'd0);
    assign w_prod = PROD_W'(f_size_coef(w_layer_one, r_pend.frame_nsamp == SAMPLES_HALF))
                  * PROD_W'(r_pend.bitrate_kbps);
    assign w_size_sum = w_dvd_nx[11:0] + {11'd0, r_pend.padding_bit};

    // ------------------------------------------------------------------
    // Sequencer, search state and pending result
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_win        <= '0;
            r_pos        <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            if (r_pend_valid && (!r_out_valid || !i_out_stall)) begin
                r_pend_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        if (i_op == OP_END) begin
                            r_pend       <= {STATUS_END, {(RES_W-2){1'b0}}};
                            r_pend_valid <= 1'b1;
                            r_win        <= '0;
                            r_pos        <= '0;
                        end else if (w_limit_hit) begin
                            r_pend       <= {STATUS_LIMIT, {(RES_W-2){1'b0}}};
                            r_pend_valid <= 1'b1;
                            r_win        <= '0;
                            r_pos        <= '0;
                        end else if (w_hdr_ok && w_type_ok) begin
                            r_pend.status         <= STATUS_FOUND;
                            r_pend.skipped_bytes  <= w_skip;
                            r_pend.version_code   <= w_ver;
                            r_pend.layer_code     <= w_lay;
                            r_pend.bitrate_kbps   <= f_bitrate(w_row, n_win[15:12]);
                            r_pend.sample_rate_hz <= f_sample_rate(w_ver, w_fri);
                            r_pend.padding_bit    <= n_win[9];
                            r_pend.chan_mode      <= n_win[7:6];
                            r_pend.frame_bytes    <= '0;
                            r_pend.frame_nsamp    <= (w_lay == 2'd0) ? SAMPLES_L1
                                                   : w_half ? SAMPLES_HALF : SAMPLES_FULL;
                            r_pend.frame_time_num <= '0;
                            r_pend.frame_time_den <= (w_fri != 2'd0) ? DEN_ONE
                                                   : (w_lay == 2'd0) ? DEN_L1 : DEN_L23;
                            r_win   <= '0;
                            r_pos   <= '0;
                            r_state <= ST_MUL;
                        end else begin
                            r_win <= n_win;
                            r_pos <= n_pos;
                        end
                    end
                end
                ST_MUL: begin
                    r_dvd   <= w_prod[DVD_W-1:0];
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_DIV_SIZE;
                end
                ST_DIV_SIZE: begin
                    if (r_cnt == DIV_LAST) begin
                        r_pend.frame_bytes <= w_layer_one ? {w_size_sum[9:0], 2'b00}
                                                          : w_size_sum;
                        r_dvd   <= f_time_dividend(w_layer_one,
                                                   r_pend.frame_nsamp == SAMPLES_HALF,
                                                   r_pend.frame_time_den == DEN_ONE);
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= ST_DIV_TIME;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                        r_dvd <= w_dvd_nx;
                        r_rem <= w_rem_nx;
                    end
                end
                ST_DIV_TIME: begin
                    if (r_cnt == DIV_LAST) begin
                        r_pend.frame_time_num <= w_dvd_nx[12:0];
                        r_pend_valid          <= 1'b1;
                        r_cnt                 <= '0;
                        r_state               <= ST_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                        r_dvd <= w_dvd_nx;
                        r_rem <= w_rem_nx;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_pend_valid && (!r_out_valid || !i_out_stall)) begin
            r_out       <= r_pend;
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_skipped_bytes  = r_out.skipped_bytes;
    assign o_version_code   = r_out.version_code;
    assign o_layer_code     = r_out.layer_code;
    assign o_bitrate_kbps   = r_out.bitrate_kbps;
    assign o_sample_rate_hz = r_out.sample_rate_hz;
    assign o_padding_bit    = r_out.padding_bit;
    assign o_chan_mode      = r_out.chan_mode;
    assign o_frame_bytes    = r_out.frame_bytes;
    assign o_frame_nsamp    = r_out.frame_nsamp;
    assign o_frame_time_num = r_out.frame_time_num;
    assign o_frame_time_den = r_out.frame_time_den;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_busy_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !r_pend_valid)
        else $error("result pending while divider busy");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DIV_SIZE) || (r_state == ST_DIV_TIME))
            |-> (r_rem < r_pend.sample_rate_hz))
        else $error("divider remainder out of range");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DIV_TIME) && (r_cnt == DIV_LAST))
            |=> (r_pend_valid && (r_state == ST_IDLE)))
        else $error("header result not posted after division");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_op == OP_END))
            |=> ((r_win == 32'd0) && (r_pos == '0) && r_pend_valid
                 && (r_pend.status == STATUS_END)))
        else $error("end of data did not clear the search");

endmodule
